/* rtl/dotq_pkg.sv */
// Shared types and codes for the deadline-ordered timer queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dotq_pkg;
  localparam logic [1:0] OP_POST   = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] KIND_POSTED    = 3'd0;
  localparam logic [2:0] KIND_DELIVERED = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_NOTHING   = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;

  localparam int RESULT_LIMIT = 16;

  // one classified command from the front end to the engine
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] now_time;
    logic [31:0] delay;
    logic [31:0] interval;
    logic [31:0] cancel_id;
  } cmd_t;
endpackage
`default_nettype wire

/* rtl/dotq_front.sv */
// Front end: accepts input beats, drops unused codes, two-entry command queue.
// Depends on dotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dotq_front #(
  parameter int TIME_BITS = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire [1:0]            in_operation,
  input  wire [31:0]           in_now_time,
  input  wire [31:0]           in_delay,
  input  wire [31:0]           in_interval,
  input  wire [31:0]           in_cancel_id,
  output logic                 cmd_valid,
  input  wire                  cmd_ready,
  output dotq_pkg::cmd_t       cmd
);
  import dotq_pkg::*;
  cmd_t q_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;
  logic [63:0] now_ext;

  always_comb begin
    now_ext = 64'(in_now_time);
    if (TIME_BITS < 32) now_ext = now_ext & ((64'd1 << TIME_BITS) - 64'd1);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign push      = in_valid && in_ready && (in_operation != OP_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: in_operation, now_time: now_ext, delay: in_delay,
                     interval: in_interval, cancel_id: in_cancel_id};
    end
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

/* rtl/dotq_engine.sv */
// Back end: sorted entry registers, sequencer for post, cancel and tick.
// Depends on dotq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dotq_engine #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            cmd_valid,
  output logic           cmd_ready,
  input  dotq_pkg::cmd_t cmd,
  output logic           out_valid,
  input  wire            out_ready,
  output logic [2:0]     out_kind,
  output logic [31:0]    out_msg_id,
  output logic           out_last
);
  import dotq_pkg::*;
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1; // cancel or tick compaction, one entry a cycle
  localparam logic [2:0] ST_EMIT = 3'd2; // deliver one due entry
  localparam logic [2:0] ST_INS  = 3'd3; // shift-insert one entry
  localparam logic [2:0] ST_OUT  = 3'd4; // wait for result slot

  logic [TIME_BITS-1:0] dl_r  [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] per_r [QUEUE_DEPTH];
  logic [31:0]          id_r  [QUEUE_DEPTH];
  logic [CW-1:0] count_r, scan_r, keep_r;
  logic [31:0]   next_id_r;
  logic [2:0]    st_r, ret_r;
  cmd_t          c_r;
  // due list
  logic [TIME_BITS-1:0] ddl_r  [RESULT_LIMIT];
  logic [TIME_BITS-1:0] dper_r [RESULT_LIMIT];
  logic [31:0]          did_r  [RESULT_LIMIT];
  logic [4:0] dn_r;
  logic [4:0] dk_r;
  // pending insert
  logic [TIME_BITS-1:0] ins_dl_r, ins_per_r;
  logic [31:0]          ins_id_r;
  // output register
  logic       ov_r;
  logic [2:0] ok_r;
  logic [31:0] oid_r;
  logic       ol_r;

  logic [TIME_BITS-1:0] nowt, sum_b, base_b;
  logic [TIME_BITS:0]   sum_w;
  logic                 slot;
  logic                 ov_set;
  logic [IW-1:0]        si, ki;
  logic                 ins_hit;

  assign nowt      = c_r.now_time[TIME_BITS-1:0];
  assign slot      = !ov_r || out_ready;
  assign cmd_ready = (st_r == ST_IDLE) && slot;
  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_msg_id = oid_r;
  assign out_last  = ol_r;
  assign si = scan_r[IW-1:0];
  assign ki = keep_r[IW-1:0];

  // a new result beat is loaded this cycle
  assign ov_set = slot && (((st_r == ST_IDLE) && cmd_valid && (cmd.op == OP_POST)) ||
                           (st_r == ST_OUT) || (st_r == ST_EMIT));

  // shared saturating adder
  always_comb begin
    if (st_r == ST_IDLE) begin
      base_b = cmd.now_time[TIME_BITS-1:0];
      sum_w  = {1'b0, base_b} + (TIME_BITS + 1)'(cmd.delay);
      if (TIME_BITS < 32 && cmd.delay[31:(TIME_BITS < 32 ? TIME_BITS : 31)] != '0
          && TIME_BITS < 32)
        sum_w = {1'b1, TMAX};
    end else begin
      base_b = (ddl_r[dk_r[3:0]] == '0) ? nowt : ddl_r[dk_r[3:0]];
      sum_w  = {1'b0, base_b} + {1'b0, dper_r[dk_r[3:0]]};
    end
    sum_b = sum_w[TIME_BITS] ? TMAX : sum_w[TIME_BITS-1:0];
  end

  // insert hits position scan_r when predecessor is not later
  assign ins_hit = (scan_r == '0) || !(dl_r[IW'(scan_r - 1'b1)] > ins_dl_r);

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (cmd_valid && slot) begin
          c_r    <= cmd;
          keep_r <= '0;
          dn_r   <= '0;
          dk_r   <= '0;
          ins_dl_r  <= (cmd.delay == '0) ? '0 : sum_b;
          ins_per_r <= TIME_BITS'(cmd.interval);
          ins_id_r  <= next_id_r;
          // post inserts from the tail, cancel and tick scan from the head
          scan_r    <= (cmd.op == OP_POST) ? count_r : '0;
        end
      end
      ST_SCAN: begin
        if (scan_r < count_r) begin
          if (c_r.op == OP_CANCEL ? (id_r[si] != c_r.cancel_id) :
              !(dn_r < 5'(RESULT_LIMIT) &&
                (dl_r[si] == '0 || nowt >= dl_r[si]))) begin
            dl_r[ki] <= dl_r[si]; per_r[ki] <= per_r[si]; id_r[ki] <= id_r[si];
            keep_r <= keep_r + 1'b1;
          end else if (c_r.op == OP_TICK) begin
            ddl_r[dn_r[3:0]] <= dl_r[si]; dper_r[dn_r[3:0]] <= per_r[si];
            did_r[dn_r[3:0]] <= id_r[si];
            dn_r <= dn_r + 1'b1;
          end
          scan_r <= scan_r + 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot && dper_r[dk_r[3:0]] != '0) begin
          ins_dl_r <= sum_b; ins_per_r <= dper_r[dk_r[3:0]];
          ins_id_r <= did_r[dk_r[3:0]];
          scan_r <= count_r;
        end
        if (slot) dk_r <= dk_r + 1'b1;
      end
      ST_INS: begin
        if (count_r < CW'(QUEUE_DEPTH)) begin
          if (ins_hit) begin
            dl_r[si] <= ins_dl_r; per_r[si] <= ins_per_r; id_r[si] <= ins_id_r;
          end else begin
            dl_r[si] <= dl_r[IW'(scan_r - 1'b1)];
            per_r[si] <= per_r[IW'(scan_r - 1'b1)];
            id_r[si] <= id_r[IW'(scan_r - 1'b1)];
            scan_r <= scan_r - 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (!rst_n) begin
      st_r <= ST_IDLE; ret_r <= ST_IDLE; count_r <= '0; next_id_r <= '0; ov_r <= 1'b0;
    end else begin
      if (ov_set) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (cmd_valid && slot) begin
            case (cmd.op)
              OP_POST: begin
                ol_r <= 1'b1;
                if (count_r >= CW'(QUEUE_DEPTH)) begin
                  ok_r <= KIND_FULL; oid_r <= '0;
                end else begin
                  ok_r <= KIND_POSTED; oid_r <= next_id_r;
                  next_id_r <= next_id_r + 1'b1;
                  st_r <= ST_INS; ret_r <= ST_IDLE;
                end
              end
              OP_CANCEL, OP_TICK: st_r <= ST_SCAN;
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_r >= count_r) begin
            count_r <= keep_r;
            if (c_r.op == OP_CANCEL || dn_r == '0) begin
              st_r <= ST_OUT;
              ok_r <= (c_r.op == OP_CANCEL) ? KIND_CANCELLED : KIND_NOTHING;
              oid_r <= '0; ol_r <= 1'b1;
            end else st_r <= ST_EMIT;
          end
        end
        ST_OUT: begin
          if (slot) st_r <= ST_IDLE;
        end
        ST_EMIT: begin
          if (slot) begin
            ok_r <= KIND_DELIVERED; oid_r <= did_r[dk_r[3:0]];
            ol_r <= (dk_r + 1'b1 == dn_r);
            if (dper_r[dk_r[3:0]] != '0) begin
              st_r <= ST_INS;
              ret_r <= (dk_r + 1'b1 == dn_r) ? ST_IDLE : ST_EMIT;
            end else if (dk_r + 1'b1 == dn_r) st_r <= ST_IDLE;
          end
        end
        ST_INS: begin
          if (count_r >= CW'(QUEUE_DEPTH)) st_r <= ret_r;
          else if (ins_hit) begin
            count_r <= count_r + 1'b1; st_r <= ret_r;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/deadline_ordered_timer_queue.sv */
// Top level of the deadline-ordered timer queue.
// Depends on dotq_pkg, dotq_front, dotq_engine.
//
// Input channel in_*: one beat is post, cancel or tick. Output channel out_*:
// result beats, out_last marks the final result of an input beat.
// A two-beat command queue decouples intake from the engine.
// A post result passes through the command queue register and then the engine's
// output register; the insert then follows (shift-insert, one entry a cycle).
// Cancel and tick scan all entries, one a cycle; a tick then emits one
// delivery per cycle while the receiver takes them, each periodic entry being
// reinserted before the next delivery.
// Throughput: the engine runs one command at a time, so the rate is set by
// the entry count, not by the command queue.
// Operation code 3 is dropped with no result.
// Reset clears counts and id counter; entry storage is not cleared.
// A stalled receiver holds the output register; the engine waits and the
// command queue fills, after which in_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module deadline_ordered_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire [1:0]   in_operation,
  input  wire [31:0]  in_now_time,
  input  wire [31:0]  in_delay,
  input  wire [31:0]  in_interval,
  input  wire [31:0]  in_cancel_id,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_msg_id,
  output logic        out_last
);
  import dotq_pkg::*;
  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  dotq_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_operation, .in_now_time,
    .in_delay, .in_interval, .in_cancel_id, .cmd_valid, .cmd_ready, .cmd);

  dotq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .TIME_BITS(TIME_BITS)) u_engine (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_kind, .out_msg_id, .out_last);
endmodule
`default_nettype wire

/* rtl/dotq_checker.sv */
// Port-level checks for the timer queue, bound to the top level.
// Depends on dotq_pkg and the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module dotq_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  out_kind,
  input wire [31:0] out_msg_id,
  input wire        out_last
);
  import dotq_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_msg_id))
    else $error("result beat dropped under stall");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_FULL) else $error("bad kind");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_DELIVERED |-> out_last)
    else $error("non-delivery not last");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_CANCELLED || out_kind == KIND_NOTHING ||
                  out_kind == KIND_FULL)
    |-> out_msg_id == 32'd0) else $error("msg_id not zero");
endmodule
bind deadline_ordered_timer_queue dotq_checker u_chk (.clk, .rst_n, .out_valid,
  .out_ready, .out_kind, .out_msg_id, .out_last);
`default_nettype wire
